// ===== rtl/lidar_point_camera_projection_unit_macros.svh =====
// Assertion macros for the lidar point camera projection unit.
// Used by the top-level RTL module; has no other dependencies.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_UNIT_MACROS_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LPCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpcp assertion failed");
// Next-cycle implication.
`define LPCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpcp assertion failed");
`else
`define LPCP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LPCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lpcp_pkg.sv =====
// Shared constants, codes and types of the lidar point camera projection unit.
// No dependencies.
package lpcp_pkg;
	localparam int COORD_WIDTH  = 32;
	localparam int STORE_DEPTH  = 28;
	localparam int PROJ_BASE    = 16;
	localparam int MAX_IMAGE    = 4096;
	localparam int H_W          = 42;   // projected homogeneous component
	localparam int N_W          = 56;   // component times image size
	localparam int Q_W          = 12;   // pixel coordinate
	localparam int DIV_STEPS    = Q_W + 1;
	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [1:0] ST_BEHIND  = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_VISIBLE = 2'd2;
	localparam logic [1:0] ST_DEGEN   = 2'd3;

	// Flags that travel beside the dividers.
	typedef struct packed {
		logic pv;
		logic kept;
		logic degen;
		logic neg_u;
		logic neg_v;
		logic last;
	} side_t;

	// Product of a Q8.24 coefficient and a Q16.16 value, floored to Q16.16.
	function automatic logic signed [39:0] q24_term(input logic signed [63:0] prod);
		return prod[63:24];
	endfunction
endpackage

// ===== rtl/lidar_point_camera_projection_unit.sv =====
// Top level of the lidar point camera projection unit: coefficient store,
// both matrix products, scaling and status. Depends on lpcp_pkg, lpcp_div
// and the assertion macro header.
//
// Channel   Direction  Handshake                Contents
// s_axis    in         s_axis_tvalid/tready     load or point item
// m_axis    out        m_axis_tvalid/tready     pixel, status, end of cloud
// cfg       in         cfg_valid/cfg_ready      image width and height
//
// One item enters per cycle unless a full output register is not taken.
// Loads take effect in item order: extrinsic words at stage 1, projection
// words at stage 3, so earlier points see the old and later ones the new value.
// All stages advance together when the output register is empty or taken.
// Reset restores the image size and clears the coefficient store at once.
`include "lidar_point_camera_projection_unit_macros.svh"
module lidar_point_camera_projection_unit #(
	parameter int COORD_WIDTH = lpcp_pkg::COORD_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// coef_index[4:0], coef_value[36:5], point_x[68:37], point_y[100:69],
	// point_z[132:101], zeros above
	input  logic [135:0] s_axis_tdata,
	input  logic         s_axis_tuser,   // kind
	input  logic         s_axis_tlast,   // last_point
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pixel_col[11:0], pixel_row[23:12], status[25:24], zeros above
	output logic [31:0]  m_axis_tdata,
	output logic         m_axis_tlast,   // end_of_cloud
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [12:0]  cfg_data
);
	localparam int PW = (COORD_WIDTH >= 32) ? 32 : COORD_WIDTH;
	localparam int SH = 32 - PW;
	localparam int HW = lpcp_pkg::H_W;
	localparam int NW = lpcp_pkg::N_W;
	localparam int DS = lpcp_pkg::DIV_STEPS;

	logic adv, in_acc;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_acc = s_axis_tvalid && adv;

	// Configuration registers.
	logic [12:0] width_q, height_q, w_c, h_c;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lpcp_pkg::WIDTH_RESET;
			height_q <= lpcp_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == lpcp_pkg::REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
		end
	end
	assign w_c = (width_q > 13'(lpcp_pkg::MAX_IMAGE)) ? 13'(lpcp_pkg::MAX_IMAGE) : width_q;
	assign h_c = (height_q > 13'(lpcp_pkg::MAX_IMAGE)) ? 13'(lpcp_pkg::MAX_IMAGE) : height_q;

	// Input fields, points sign-extended from the coordinate width.
	logic signed [31:0] p_in [0:2];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_in[i] = signed'(s_axis_tdata[37 + 32*i +: 32] << SH) >>> SH;
		end
	end

	// Stage 1: input register.
	logic               pv_s1, ld_s1, last_s1;
	logic [4:0]         idx_s1;
	logic [31:0]        val_s1;
	logic signed [31:0] p_s1 [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else if (adv) begin
			pv_s1 <= in_acc && (s_axis_tuser == lpcp_pkg::KIND_POINT);
			ld_s1 <= in_acc && (s_axis_tuser == lpcp_pkg::KIND_LOAD);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= s_axis_tdata[4:0];
			val_s1  <= s_axis_tdata[36:5];
			last_s1 <= s_axis_tlast;
			for (int i = 0; i < 3; i++) p_s1[i] <= p_in[i];
		end
	end

	// Load items ride the pipe to stage 3 for the projection words.
	logic        ld_s2, ld_s3;
	logic [4:0]  idx_s2, idx_s3;
	logic [31:0] val_s2, val_s3;
	logic [4:0]  pidx;
	assign pidx = idx_s3 - 5'(lpcp_pkg::PROJ_BASE);

	// Coefficient store, written at the stage that reads each matrix.
	logic signed [31:0] e_q [0:15];
	logic signed [31:0] pm_q [0:11];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) e_q[i] <= '0;
			for (int i = 0; i < 12; i++) pm_q[i] <= '0;
		end else if (adv) begin
			if (ld_s1 && idx_s1 < 5'(lpcp_pkg::PROJ_BASE)) e_q[idx_s1[3:0]] <= val_s1;
			if (ld_s3 && idx_s3 >= 5'(lpcp_pkg::PROJ_BASE)
				&& idx_s3 < 5'(lpcp_pkg::STORE_DEPTH)) begin
				pm_q[pidx[3:0]] <= val_s3;
			end
		end
	end

	// Stage 2: extrinsic products; the homogeneous one is a shift.
	logic               pv_s2, last_s2;
	logic signed [39:0] et_s2 [0:15];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s2 <= 1'b0;
			ld_s2 <= 1'b0;
			ld_s3 <= 1'b0;
		end else if (adv) begin
			pv_s2 <= pv_s1;
			ld_s2 <= ld_s1;
			ld_s3 <= ld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			last_s2 <= last_s1;
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 3; k++) begin
					et_s2[r*4+k] <= lpcp_pkg::q24_term(64'(e_q[r*4+k]) * 64'(p_s1[k]));
				end
				et_s2[r*4+3] <= 40'(e_q[r*4+3]) >>> 8;
			end
		end
	end

	// Stage 3: camera coordinates, saturated, and the keep test.
	logic               pv_s3, last_s3, kept_s3;
	logic signed [31:0] c_s3 [0:3];
	logic signed [HW-1:0] csum [0:3];
	logic signed [31:0] csat [0:3];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			csum[r] = HW'(et_s2[r*4]) + HW'(et_s2[r*4+1]) + HW'(et_s2[r*4+2])
				+ HW'(et_s2[r*4+3]);
			if (csum[r] > HW'(32'sh7fffffff)) csat[r] = 32'sh7fffffff;
			else if (csum[r] < -HW'(33'sh080000000)) csat[r] = 32'sh80000000;
			else csat[r] = csum[r][31:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s3 <= 1'b0;
		else if (adv) pv_s3 <= pv_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= last_s2;
			for (int r = 0; r < 4; r++) c_s3[r] <= csat[r];
			kept_s3 <= (csat[0] > 0 && csat[3] >= 0) || (csat[0] < 0 && csat[3] < 0);
		end
	end

	// Stage 4: projection products.
	logic               pv_s4, last_s4, kept_s4;
	logic signed [39:0] pt_s4 [0:11];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s4 <= 1'b0;
		else if (adv) pv_s4 <= pv_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4 <= last_s3;
			kept_s4 <= kept_s3;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 4; k++) begin
					pt_s4[r*4+k] <= lpcp_pkg::q24_term(64'(pm_q[r*4+k]) * 64'(c_s3[k]));
				end
			end
		end
	end

	// Stage 5: homogeneous image point.
	logic                 pv_s5, last_s5, kept_s5;
	logic signed [HW-1:0] h_s5 [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s5 <= 1'b0;
		else if (adv) pv_s5 <= pv_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s5 <= last_s4;
			kept_s5 <= kept_s4;
			for (int r = 0; r < 3; r++) begin
				h_s5[r] <= HW'(pt_s4[r*4]) + HW'(pt_s4[r*4+1]) + HW'(pt_s4[r*4+2])
					+ HW'(pt_s4[r*4+3]);
			end
		end
	end

	// Stage 6: scale by the image size.
	logic                 pv_s6, last_s6, kept_s6;
	logic signed [NW-1:0] nu_s6, nv_s6;
	logic signed [HW-1:0] d_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s6 <= 1'b0;
		else if (adv) pv_s6 <= pv_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s6 <= last_s5;
			kept_s6 <= kept_s5;
			nu_s6   <= NW'(h_s5[0]) * NW'(signed'({1'b0, w_c}));
			nv_s6   <= NW'(h_s5[1]) * NW'(signed'({1'b0, h_c}));
			d_s6    <= h_s5[2];
		end
	end

	// Stage 7: magnitudes and quotient signs.
	lpcp_pkg::side_t      side_s7;
	logic [NW-1:0]        mu_s7, mv_s7;
	logic [HW-1:0]        md_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else if (adv) begin
			side_s7.pv    <= pv_s6;
			side_s7.last  <= last_s6;
			side_s7.kept  <= kept_s6;
			side_s7.degen <= (d_s6 == '0);
			side_s7.neg_u <= nu_s6[NW-1] ^ d_s6[HW-1];
			side_s7.neg_v <= nv_s6[NW-1] ^ d_s6[HW-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mu_s7 <= nu_s6[NW-1] ? NW'(-nu_s6) : NW'(nu_s6);
			mv_s7 <= nv_s6[NW-1] ? NW'(-nv_s6) : NW'(nv_s6);
			md_s7 <= d_s6[HW-1] ? HW'(-d_s6) : HW'(d_s6);
		end
	end

	// Dividers, with the flags delayed alongside.
	logic [lpcp_pkg::Q_W-1:0] qu, qv;
	logic                     ovf_u, ovf_v;
	lpcp_div u_div_col (.clk(clk), .en(adv), .num(mu_s7), .den(md_s7), .quo(qu), .ovf(ovf_u));
	lpcp_div u_div_row (.clk(clk), .en(adv), .num(mv_s7), .den(md_s7), .quo(qv), .ovf(ovf_v));

	lpcp_pkg::side_t side_sd [1:DS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DS; i++) side_sd[i] <= '0;
		end else if (adv) begin
			side_sd[1] <= side_s7;
			for (int i = 2; i <= DS; i++) side_sd[i] <= side_sd[i-1];
		end
	end

	// Status decision and output register.
	lpcp_pkg::side_t sf;
	logic            in_u, in_v;
	logic [1:0]      st_d;
	assign sf   = side_sd[DS];
	assign in_u = !ovf_u && ({1'b0, qu} < w_c) && (qu == '0 || !sf.neg_u);
	assign in_v = !ovf_v && ({1'b0, qv} < h_c) && (qv == '0 || !sf.neg_v);
	always_comb begin
		if (!sf.kept) st_d = lpcp_pkg::ST_BEHIND;
		else if (sf.degen) st_d = lpcp_pkg::ST_DEGEN;
		else if (in_u && in_v) st_d = lpcp_pkg::ST_VISIBLE;
		else st_d = lpcp_pkg::ST_OUTSIDE;
	end

	logic [11:0] col_q, row_q;
	logic [1:0]  status_q;
	logic        last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (adv) m_axis_tvalid <= sf.pv;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= st_d;
			col_q    <= (st_d == lpcp_pkg::ST_VISIBLE) ? qu : '0;
			row_q    <= (st_d == lpcp_pkg::ST_VISIBLE) ? qv : '0;
			last_q   <= sf.last;
		end
	end
	assign m_axis_tdata = {6'd0, status_q, row_q, col_q};
	assign m_axis_tlast = last_q;

	// Checks.
	`LPCP_ASSERT_NOW(a_pixels_zero, clk, arst_n,
		m_axis_tvalid && status_q != lpcp_pkg::ST_VISIBLE, col_q == '0 && row_q == '0)
	`LPCP_ASSERT_NEXT(a_stall_holds_h, clk, arst_n, !adv, $stable(h_s5[2]) && $stable(pv_s5))
	`LPCP_ASSERT_NOW(a_load_not_point, clk, arst_n, ld_s1, !pv_s1)
endmodule

// ===== rtl/lpcp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned operands.
// Depends on lpcp_pkg; the first stage flags quotients of 4096 or more.
module lpcp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lpcp_pkg::N_W-1:0]      num,
	input  logic [lpcp_pkg::H_W-1:0]      den,
	output logic [lpcp_pkg::Q_W-1:0]      quo,
	output logic                          ovf
);
	localparam int RW = lpcp_pkg::N_W + 1;
	localparam int ST = lpcp_pkg::DIV_STEPS;

	logic [RW-1:0]               rem_s [1:ST];
	logic [lpcp_pkg::H_W-1:0]    den_s [1:ST];
	logic [lpcp_pkg::Q_W-1:0]    quo_s [1:ST];
	logic                        ovf_s [1:ST];

	for (genvar k = 0; k < ST; k++) begin : g_step
		localparam int B = ST - 1 - k;
		logic [RW-1:0]              r_in;
		logic [lpcp_pkg::H_W-1:0]   d_in;
		logic [lpcp_pkg::Q_W-1:0]   q_in;
		logic                       o_in;
		logic [RW-1:0]              sub;
		logic [RW:0]                diff;
		logic                       take;

		if (k == 0) begin : g_first
			assign r_in = RW'(num);
			assign d_in = den;
			assign q_in = '0;
			assign o_in = 1'b0;
		end else begin : g_next
			assign r_in = rem_s[k];
			assign d_in = den_s[k];
			assign q_in = quo_s[k];
			assign o_in = ovf_s[k];
		end

		// Trial subtraction of the shifted divisor.
		assign sub  = RW'(d_in) << B;
		assign diff = {1'b0, r_in} - {1'b0, sub};
		assign take = !diff[RW];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[RW-1:0] : r_in;
				den_s[k+1] <= d_in;
				if (k == 0) begin
					ovf_s[k+1] <= take;
					quo_s[k+1] <= q_in;
				end else begin
					ovf_s[k+1] <= o_in;
					quo_s[k+1] <= q_in | (lpcp_pkg::Q_W'(take) << B);
				end
			end
		end
	end

	assign quo = quo_s[ST];
	assign ovf = ovf_s[ST];
endmodule

// ===== verif/lidar_point_camera_projection_unit_tb.sv =====
// Self-checking testbench for the lidar point camera projection unit.
// Drives load and point beats, predicts every pixel result and checks it.
// Depends on lpcp_pkg and the unit's RTL.
`timescale 1ns / 100ps

module lidar_point_camera_projection_unit_tb;
	localparam int LATENCY_WAIT = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [31:0] ONE_Q24  = 32'h0100_0000;
	localparam logic [31:0] HALF_Q24 = 32'h0080_0000;

	typedef struct {
		logic               kind;
		logic [4:0]         idx;
		logic signed [31:0] coef;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} beat_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic [1:0]  status;
		logic        last;
	} pixel_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [12:0]  cfg_data;

	beat_t       pending_beats[$];
	pixel_t      expected_pixels[$];
	logic [31:0] coef_mirror[lpcp_pkg::STORE_DEPTH];
	logic [31:0] nominal_coef[lpcp_pkg::STORE_DEPTH];
	logic [12:0] width_mirror;
	logic [12:0] height_mirror;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          errors;
	int          cycles;
	bit          in_beat_taken;

	lidar_point_camera_projection_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Floored Q8.24 by Q16.16 product, giving a Q16.16 term.
	function automatic longint q24_mul(logic [31:0] c, longint val);
		longint prod;
		prod = longint'($signed(c)) * val;
		return prod >>> 24;
	endfunction

	// Expected pixel for one point beat, from the mirrored store and sizes.
	function automatic pixel_t project_point(beat_t b);
		longint pt[4];
		longint cam[4];
		longint hom[3];
		longint acc, w, ht, u, v;
		pixel_t res;
		bit kept;
		pt[0] = longint'(b.x);
		pt[1] = longint'(b.y);
		pt[2] = longint'(b.z);
		pt[3] = 64'sd65536;
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += q24_mul(coef_mirror[r * 4 + k], pt[k]);
			if (acc > 64'sd2147483647)
				acc = 64'sd2147483647;
			else if (acc < -64'sd2147483648)
				acc = -64'sd2147483648;
			cam[r] = acc;
		end
		res.col = '0;
		res.row = '0;
		res.status = lpcp_pkg::ST_BEHIND;
		res.last = b.last;
		kept = (cam[0] > 0 && cam[3] >= 0) || (cam[0] < 0 && cam[3] < 0);
		if (kept) begin
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += q24_mul(coef_mirror[lpcp_pkg::PROJ_BASE + r * 4 + k], cam[k]);
				hom[r] = acc;
			end
			if (hom[2] == 0) begin
				res.status = lpcp_pkg::ST_DEGEN;
			end else begin
				w = (width_mirror > lpcp_pkg::MAX_IMAGE) ? lpcp_pkg::MAX_IMAGE : width_mirror;
				ht = (height_mirror > lpcp_pkg::MAX_IMAGE) ? lpcp_pkg::MAX_IMAGE
					: height_mirror;
				u = (hom[0] * w) / hom[2];
				v = (hom[1] * ht) / hom[2];
				if (u >= 0 && u < w && v >= 0 && v < ht) begin
					res.status = lpcp_pkg::ST_VISIBLE;
					res.col = u[11:0];
					res.row = v[11:0];
				end else begin
					res.status = lpcp_pkg::ST_OUTSIDE;
				end
			end
		end
		return res;
	endfunction

	task automatic queue_load(int idx, logic [31:0] val);
		beat_t b;
		b = '{lpcp_pkg::KIND_LOAD, idx[4:0], val, $urandom(), $urandom(), $urandom(),
			$urandom_range(1)};
		pending_beats.push_back(b);
	endtask

	task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
		beat_t b;
		b = '{lpcp_pkg::KIND_POINT, $urandom_range(31), $urandom(), x, y, z, last};
		pending_beats.push_back(b);
	endtask

	task automatic load_nominal_camera();
		for (int i = 0; i < lpcp_pkg::STORE_DEPTH; i++)
			queue_load(i, nominal_coef[i]);
	endtask

	// A point in front of the camera with lateral offsets up to 1.2 times its range.
	task automatic queue_forward_point();
		int range_q, span;
		range_q = $urandom_range(32'h0032_0000, 32'h0000_4000);
		span = range_q + range_q / 5;
		queue_point(range_q, $urandom_range(2 * span) - span,
			$urandom_range(2 * span) - span, $urandom_range(9) == 0);
	endtask

	task automatic wait_until_drained();
		while (pending_beats.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [12:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == lpcp_pkg::REG_WIDTH)
			width_mirror = val;
		else
			height_mirror = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: hold a beat until taken, then fetch the next one or idle.
	always @(negedge clk) begin
		beat_t b;
		if (arst_n) begin
			if (!s_axis_tvalid || in_beat_taken) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					b = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= b.kind;
					s_axis_tlast <= b.last;
					s_axis_tdata <= {3'b000, b.z, b.y, b.x, b.coef, b.idx};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each accepted input beat, check each output beat.
	always @(posedge clk) begin
		beat_t b;
		pixel_t want, got;
		in_beat_taken = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_beat_taken = 1'b1;
				b.kind = s_axis_tuser;
				b.idx = s_axis_tdata[4:0];
				b.coef = s_axis_tdata[36:5];
				b.x = s_axis_tdata[68:37];
				b.y = s_axis_tdata[100:69];
				b.z = s_axis_tdata[132:101];
				b.last = s_axis_tlast;
				if (b.kind == lpcp_pkg::KIND_POINT)
					expected_pixels.push_back(project_point(b));
				else if (b.idx < lpcp_pkg::STORE_DEPTH)
					coef_mirror[b.idx] = b.coef;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[25:24],
					m_axis_tlast};
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat col=%0d row=%0d status=%0d last=%0b",
						$time, got.col, got.row, got.status, got.last);
				end else begin
					want = expected_pixels.pop_front();
					if (got.col !== want.col) begin
						errors++;
						$display("%0t: pixel_col expected %0d actual %0d", $time, want.col, got.col);
					end
					if (got.row !== want.row) begin
						errors++;
						$display("%0t: pixel_row expected %0d actual %0d", $time, want.row, got.row);
					end
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
					end
					if (got.last !== want.last) begin
						errors++;
						$display("%0t: end_of_cloud expected %0b actual %0b", $time,
							want.last, got.last);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lidar_point_camera_projection_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int pick, k;
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lpcp_pkg::REG_WIDTH;
		cfg_data = '0;
		width_mirror = lpcp_pkg::WIDTH_RESET;
		height_mirror = lpcp_pkg::HEIGHT_RESET;
		foreach (coef_mirror[i]) begin
			coef_mirror[i] = '0;
			nominal_coef[i] = '0;
		end
		// Identity extrinsic; u/w = (x - y) / 2x, v/h = (x - z) / 2x.
		nominal_coef[0] = ONE_Q24;
		nominal_coef[5] = ONE_Q24;
		nominal_coef[10] = ONE_Q24;
		nominal_coef[15] = ONE_Q24;
		nominal_coef[16] = HALF_Q24;
		nominal_coef[17] = -HALF_Q24;
		nominal_coef[20] = HALF_Q24;
		nominal_coef[22] = -HALF_Q24;
		nominal_coef[24] = ONE_Q24;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: cleared store gives a zero camera x, so every point is behind.
		queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
		load_nominal_camera();
		queue_point(32'h000A_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_point(32'h000A_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_point(32'h000A_0000, 32'h0010_0000, 32'h0000_0000, 1'b0);
		queue_point(32'hFFF6_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		// Negative camera x with negative w is kept; positive x then is not.
		queue_load(15, -ONE_Q24);
		queue_point(32'hFFF6_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		queue_point(32'h000A_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		queue_load(15, ONE_Q24);
		// Zero third projection row gives a degenerate divisor.
		queue_load(24, 32'h0000_0000);
		queue_point(32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
		queue_load(24, ONE_Q24);
		// Saturation of the camera coordinates, and an out-of-range load.
		queue_load(0, 32'h7FFF_FFFF);
		queue_load(31, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_load(0, ONE_Q24);
		queue_point(32'h0003_0000, 32'hFFFE_8000, 32'h0001_4000, 1'b1);
		wait_until_drained();
		// Oversized width and zero height.
		write_register(lpcp_pkg::REG_WIDTH, 13'h1FFF);
		write_register(lpcp_pkg::REG_HEIGHT, 13'h0000);
		for (int i = 0; i < 6; i++)
			queue_forward_point();
		wait_until_drained();

		// Random phases under each idling pattern and a new image size.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37; recv_idle_pct = 55;
					write_register(lpcp_pkg::REG_WIDTH, 13'd1920);
					write_register(lpcp_pkg::REG_HEIGHT, 13'd1080);
				end
				1: begin
					send_idle_pct = 55; recv_idle_pct = 37;
					write_register(lpcp_pkg::REG_WIDTH, 13'd4096);
					write_register(lpcp_pkg::REG_HEIGHT, 13'd1);
				end
				default: begin
					send_idle_pct = 0; recv_idle_pct = 0;
					write_register(lpcp_pkg::REG_WIDTH, 13'd1);
					write_register(lpcp_pkg::REG_HEIGHT, 13'd4096);
				end
			endcase
			load_nominal_camera();
			for (int n = 0; n < 210; n++) begin
				pick = $urandom_range(99);
				if (pick < 82) begin
					queue_forward_point();
				end else if (pick < 88) begin
					queue_point($urandom(), $urandom(), $urandom(), $urandom_range(1));
				end else if (pick < 94) begin
					// Small perturbation of one nominal coefficient.
					k = $urandom_range(lpcp_pkg::STORE_DEPTH - 1);
					queue_load(k, nominal_coef[k] + $urandom_range(32'h0040_0000) - 32'h0020_0000);
				end else if (pick < 97) begin
					queue_load($urandom_range(31), $urandom());
				end else begin
					load_nominal_camera();
				end
			end
			wait_until_drained();
		end

		if (errors == 0)
			$display("lidar_point_camera_projection_unit regression: pass");
		else
			$display("lidar_point_camera_projection_unit regression: fail");
		$finish;
	end
endmodule
